### src/tmvp_pkg.sv
// Package for the transposed matrix-vector product block.
// Word types, field widths and the column-count clamp; no dependencies.
package tmvp_pkg;

    localparam int DATA_W           = 32;
    localparam int COL_W            = 10;
    localparam int CFG_W            = 11;
    localparam int HW_COLS          = 1024;
    localparam int MAX_COLS_DEFAULT = 1024;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // input word: one matrix element with its row's vector element
    typedef struct packed {
        logic signed [DATA_W-1:0] matrix_elem;
        logic signed [DATA_W-1:0] vector_elem;
        logic [COL_W-1:0]         col_index;
        logic                     first_row;
        logic                     last_row;
    } elem_t;

    // output word: one finished column sum
    typedef struct packed {
        logic signed [DATA_W-1:0] column_sum;
        logic [COL_W-1:0]         out_col;
        logic                     last_col;
    } sum_t;

    // per-word control carried down the pipe
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             first_row;
        logic             last_row;
        logic             hit;       // column below effective n
        logic             last_col;
    } ctl_t;

    // effective n: zero reads as one, clamped to the store size
    function automatic logic [CFG_W-1:0] eff_cols(input logic [CFG_W-1:0] cols,
                                                  input logic [CFG_W-1:0] limit);
        logic [CFG_W-1:0] n;
        n = cols;
        if (n == '0)
        begin
            n = CFG_W'(1);
        end
        if (n > limit)
        begin
            n = limit;
        end
        return n;
    endfunction

endpackage

### src/tmvp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tmvp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/tmvp_front.sv
// Input stage: registers the incoming word, checks its column, multiplies.
// Uses tmvp_pkg.
module tmvp_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   elem_valid,
    output logic                   elem_ready,
    input  tmvp_pkg::elem_t        elem,
    input  logic [tmvp_pkg::CFG_W-1:0] n_eff,
    input  logic                   down_ready,
    output logic                   s1_valid,
    output tmvp_pkg::ctl_t         s1_ctl,
    output logic [tmvp_pkg::DATA_W-1:0] s1_prod
);
    import tmvp_pkg::*;

    logic                     v1_reg;
    logic signed [DATA_W-1:0] m_reg;
    logic signed [DATA_W-1:0] vec_reg;
    ctl_t                     ctl_reg;
    ctl_t                     ctl_next;

    assign elem_ready = !v1_reg || down_ready;

    always_comb
    begin
        ctl_next.col       = elem.col_index;
        ctl_next.first_row = elem.first_row;
        ctl_next.last_row  = elem.last_row;
        ctl_next.hit       = {1'b0, elem.col_index} < n_eff;
        ctl_next.last_col  = {1'b0, elem.col_index} == (n_eff - CFG_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (elem_ready)
        begin
            v1_reg <= elem_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_ready && elem_valid)
        begin
            m_reg   <= elem.matrix_elem;
            vec_reg <= elem.vector_elem;
            ctl_reg <= ctl_next;
        end
    end

    // low half of the product, same for signed and unsigned
    assign s1_prod  = DATA_W'(m_reg * vec_reg);
    assign s1_valid = v1_reg;
    assign s1_ctl   = ctl_reg;

endmodule

### src/tmvp_accum.sv
// Accumulate stage: per-column store read, forward, add and write back.
// Uses tmvp_pkg and tmvp_ram.
module tmvp_accum #(
    parameter int unsigned MAX_COLS = tmvp_pkg::MAX_COLS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s1_valid,
    input  tmvp_pkg::ctl_t         s1_ctl,
    input  logic [tmvp_pkg::DATA_W-1:0] s1_prod,
    output logic                   s2_ready,
    input  logic                   down_ready,
    output logic                   res_valid,
    output tmvp_pkg::sum_t         res
);
    import tmvp_pkg::*;

    localparam int LIMIT = (MAX_COLS < HW_COLS) ? int'(MAX_COLS) : HW_COLS;
    localparam int AW    = (LIMIT > 1) ? $clog2(LIMIT) : 1;

    logic              v2_reg;
    ctl_t              ctl2_reg;
    logic [DATA_W-1:0] prod_reg;

    logic              lw_valid_reg;
    logic [AW-1:0]     lw_col_reg;
    logic [DATA_W-1:0] lw_acc_reg;

    logic              we;
    logic              re;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [DATA_W-1:0] rdata;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] acc;
    logic              fwd;

    assign s2_ready = !v2_reg || down_ready;

    assign re    = s2_ready && s1_valid;
    assign raddr = s1_ctl.col[AW-1:0];
    assign we    = v2_reg && down_ready && ctl2_reg.hit;
    assign waddr = ctl2_reg.col[AW-1:0];

    tmvp_ram #(
        .WIDTH(DATA_W),
        .DEPTH(LIMIT)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(acc),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    // the only write the read can miss is the latest one
    assign fwd  = lw_valid_reg && (lw_col_reg == waddr);
    assign base = fwd ? lw_acc_reg : rdata;
    assign acc  = ctl2_reg.first_row ? prod_reg : base + prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg       <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
            begin
                v2_reg <= s1_valid;
            end
            if (we)
            begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid)
        begin
            ctl2_reg <= s1_ctl;
            prod_reg <= s1_prod;
        end
        if (we)
        begin
            lw_col_reg <= waddr;
            lw_acc_reg <= acc;
        end
    end

    assign res_valid      = v2_reg && ctl2_reg.hit && ctl2_reg.last_row;
    assign res.column_sum = acc;
    assign res.out_col    = ctl2_reg.col;
    assign res.last_col   = ctl2_reg.last_col;

    // forwarding register tracks every store write
    a_lw_track: assert property (@(posedge clk) disable iff (!rst_n)
        we |=> lw_valid_reg && (lw_col_reg == $past(waddr)) && (lw_acc_reg == $past(acc)))
        else $error("forward register lost a store write");

endmodule

### src/transposed_matrix_vector_product.sv
// Pipeline: 3 stages, input, accumulate and output registers.
// Throughput: one word per cycle; input stalls only when every stage is full.
// Reset: rst_n clears the valid bits, also the forward register's, and sets cols_in_use to 1024.
// The accumulator RAM is not cleared; a column starts fresh on its first row.
// Top level; uses tmvp_pkg, tmvp_front, tmvp_accum (and tmvp_ram below it).
module transposed_matrix_vector_product #(
    parameter int unsigned MAX_COLS = tmvp_pkg::MAX_COLS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // matrix element words
    input  logic                       elem_valid,
    output logic                       elem_ready,
    input  tmvp_pkg::elem_t            elem,
    // column sum words
    output logic                       sum_valid,
    input  logic                       sum_ready,
    output tmvp_pkg::sum_t             sum,
    // cols_in_use register write
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [tmvp_pkg::CFG_W-1:0] cfg_data
);
    import tmvp_pkg::*;

    // store size: col_index is 10 bits, so never beyond HW_COLS
    localparam int LIMIT = (MAX_COLS < HW_COLS) ? int'(MAX_COLS) : HW_COLS;

    logic [CFG_W-1:0]  cols_reg;
    logic [CFG_W-1:0]  n_eff;

    logic              s1_valid;
    ctl_t              s1_ctl;
    logic [DATA_W-1:0] s1_prod;
    logic              s2_ready;
    logic              res_valid;
    sum_t              res;

    logic              sum_valid_reg;
    sum_t              sum_reg;
    logic              out_en;

    // ---------------------------------------------------------------
    // Config: always ready, not enforced by the block: user keeps it written only while the pipe is drained
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CFG_RESET;
        end
        else if (cfg_valid)
        begin
            cols_reg <= cfg_data;
        end
    end

    assign n_eff = eff_cols(cols_reg, CFG_W'(LIMIT));

    // ---------------------------------------------------------------
    // Stage 1: input register, range check, multiply
    // ---------------------------------------------------------------
    tmvp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .elem_valid(elem_valid),
        .elem_ready(elem_ready),
        .elem      (elem),
        .n_eff     (n_eff),
        .down_ready(s2_ready),
        .s1_valid  (s1_valid),
        .s1_ctl    (s1_ctl),
        .s1_prod   (s1_prod)
    );

    // ---------------------------------------------------------------
    // Stage 2: product and store read data, add with forwarding, write
    // ---------------------------------------------------------------
    tmvp_accum #(
        .MAX_COLS(MAX_COLS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_ctl    (s1_ctl),
        .s1_prod   (s1_prod),
        .s2_ready  (s2_ready),
        .down_ready(out_en),
        .res_valid (res_valid),
        .res       (res)
    );

    // ---------------------------------------------------------------
    // Stage 3: output register; words that give no result drop here
    // ---------------------------------------------------------------
    assign out_en = !sum_valid_reg || sum_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            sum_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && res_valid)
        begin
            sum_reg <= res;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;

    // an empty output stage means the whole pipe can move
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !sum_valid |-> elem_ready)
        else $error("input stalled with empty output stage");

    // a finished sum reaches the output in the next cycle when it can
    a_result_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && out_en) |=> sum_valid)
        else $error("result lost between accumulate and output stage");

endmodule
